// ===== hw/rtl/vpi_pkg.sv =====
package vpi_pkg;

  // Host operation codes.
  localparam logic [2:0] FN_CTRL_WR = 3'd0;
  localparam logic [2:0] FN_STAT_RD = 3'd1;
  localparam logic [2:0] FN_DATA_WR = 3'd2;
  localparam logic [2:0] FN_DATA_RD = 3'd3;
  localparam logic [2:0] FN_INT_ACK = 3'd4;
  localparam logic [2:0] FN_LINE    = 3'd5;

  // Interrupt levels.
  localparam logic [2:0] IPL_NONE = 3'd0;
  localparam logic [2:0] IPL_HORZ = 3'd4;
  localparam logic [2:0] IPL_VERT = 3'd6;

  // Access targets for data writes (low three code bits).
  localparam logic [2:0] WT_VRAM  = 3'd1;
  localparam logic [2:0] WT_CRAM  = 3'd3;
  localparam logic [2:0] WT_VSRAM = 3'd5;

  // Prefetch sources (low four code bits).
  localparam logic [3:0] RS_VRAM  = 4'h0;
  localparam logic [3:0] RS_CRAM  = 4'h8;
  localparam logic [3:0] RS_VSRAM = 4'h4;

  // DMA modes from the top bits of register 23.
  localparam logic [1:0] DMA_FILL = 2'd2;
  localparam logic [1:0] DMA_COPY = 2'd3;

  // Status word.
  localparam logic [9:0] STAT_RESET   = 10'h208;
  localparam logic [9:0] STAT_VBLANK  = 10'h008;
  localparam logic [9:0] STAT_VINT    = 10'h080;
  localparam logic [9:0] STAT_ONESHOT = 10'h0E0;

  // Data masks for the small memories.
  localparam logic [15:0] CRAM_MASK  = 16'h0EEE;
  localparam logic [15:0] VSRAM_MASK = 16'h07FF;

endpackage

// ===== hw/rtl/video_port_interface_with_dma.sv =====
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+-----------------------------
// input    | in_func, in_data_value, in_ack_level, in_line_number | taken when start && !busy
// result   | out_read_data, out_ipl_level                      | out_valid for one cycle
//
// Register writes, status reads, acks and scanlines go straight to S_DONE and back to idle.
// Data reads and prefetching control writes go through S_PF_A and S_PF_B, plus S_PF_C for VRAM.
// VRAM data writes go through S_DW and S_WR_LO; other data writes through S_DW alone.
// Fill DMA writes each byte in S_FILL; copy DMA does one VRAM read then one write per byte.
// After reset the block sweeps every VRAM byte to zero with busy high.
// The result strobe comes in the first idle cycle; the receiver cannot stall.
module video_port_interface_with_dma #(
  parameter int VRAM_BYTES        = 65536,
  parameter int CRAM_WORDS        = 64,
  parameter int VSRAM_WORDS       = 40,
  parameter int REG_COUNT         = 24,
  parameter int ACTIVE_LINE_COUNT = 224
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_data_value,
  input  logic [2:0]  in_ack_level,
  input  logic [8:0]  in_line_number,
  output logic        out_valid,
  output logic [15:0] out_read_data,
  output logic [2:0]  out_ipl_level
);

  import vpi_pkg::*;

  localparam int VA_W = $clog2(VRAM_BYTES);
  localparam int CA_W = $clog2(CRAM_WORDS);
  localparam int SA_W = $clog2(VSRAM_WORDS);
  localparam logic [VA_W-1:0] CLR_LAST = VA_W'(VRAM_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PF_A, S_PF_B, S_PF_C, S_DW, S_WR_LO,
    S_FILL, S_CP_RD, S_CP_WR, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [5:0]  code_r, code_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] pf_r, pf_nxt;
  logic        fillp_r, fillp_nxt;
  logic [9:0]  stat_r, stat_nxt;
  logic        lip_r, lip_nxt;
  logic [8:0]  lic_r, lic_nxt;
  logic [7:0]  regs_r [0:REG_COUNT-1];
  logic [7:0]  regs_nxt [0:REG_COUNT-1];
  logic [15:0] data_r, data_nxt;
  logic [15:0] rd_r, rd_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] src_r, src_nxt;
  logic        first_r, first_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [VA_W-1:0] clr_r, clr_nxt;
  logic        out_valid_r;
  logic [15:0] out_rd_r;
  logic [2:0]  out_ipl_r;

  logic            vram_we;
  logic [VA_W-1:0] vram_wa, vram_ra;
  logic [7:0]      vram_wd, vram_rd;
  logic            cram_we;
  logic [11:0]     cram_rd;
  logic            vsram_we;
  logic [10:0]     vsram_rd;

  // Shared address step unit and the neighbor byte address.
  logic [15:0] addr_step, addr_nbr;
  assign addr_step = addr_r + {8'd0, regs_r[15]};
  assign addr_nbr  = addr_r + 16'd1;

  logic [5:0]  ci;
  logic [14:0] vi;
  logic        ci_ok, vi_ok;
  logic [15:0] dma_len;
  assign ci      = addr_r[6:1];
  assign vi      = addr_r[15:1];
  assign ci_ok   = 32'(ci) < CRAM_WORDS;
  assign vi_ok   = 32'(vi) < VSRAM_WORDS;
  assign dma_len = ({regs_r[20], regs_r[19]} == 16'd0) ? 16'hFFFF
                                                       : {regs_r[20], regs_r[19]};

  vpi_vram #(.BYTES(VRAM_BYTES), .AW(VA_W)) u_vram (
    .clk(clk), .we(vram_we), .waddr(vram_wa), .wdata(vram_wd),
    .raddr(vram_ra), .rdata(vram_rd)
  );

  vpi_wram #(.W(12), .DEPTH(CRAM_WORDS), .AW(CA_W)) u_cram (
    .clk(clk), .rst_n(rst_n), .we(cram_we), .waddr(ci[CA_W-1:0]),
    .wdata(data_r[11:0] & CRAM_MASK[11:0]), .raddr(ci[CA_W-1:0]), .rdata(cram_rd)
  );

  vpi_wram #(.W(11), .DEPTH(VSRAM_WORDS), .AW(SA_W)) u_vsram (
    .clk(clk), .rst_n(rst_n), .we(vsram_we), .waddr(vi[SA_W-1:0]),
    .wdata(data_r[10:0] & VSRAM_MASK[10:0]), .raddr(vi[SA_W-1:0]), .rdata(vsram_rd)
  );

  // Sequencer: next state of every register and the memory ports.
  always_comb begin
    logic [5:0] code_w;
    logic [8:0] cnt9;
    state_nxt = state_r;
    addr_nxt  = addr_r;
    code_nxt  = code_r;
    pend_nxt  = pend_r;
    pf_nxt    = pf_r;
    fillp_nxt = fillp_r;
    stat_nxt  = stat_r;
    lip_nxt   = lip_r;
    lic_nxt   = lic_r;
    for (int i = 0; i < REG_COUNT; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    data_nxt  = data_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    src_nxt   = src_r;
    first_nxt = first_r;
    hi_nxt    = hi_r;
    clr_nxt   = clr_r;
    vram_we   = 1'b0;
    vram_wa   = addr_r[VA_W-1:0];
    vram_wd   = 8'd0;
    vram_ra   = addr_r[VA_W-1:0];
    cram_we   = 1'b0;
    vsram_we  = 1'b0;
    code_w    = code_r;
    cnt9      = lic_r;

    case (state_r)
      S_CLEAR: begin
        vram_we = 1'b1;
        vram_wa = clr_r;
        clr_nxt = clr_r + VA_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          rd_nxt    = 16'd0;
          data_nxt  = in_data_value;
          state_nxt = S_DONE;
          case (in_func)
            FN_CTRL_WR: begin
              if (in_data_value[15:14] == 2'b10 && !pend_r) begin
                if (32'(in_data_value[12:8]) < REG_COUNT) begin
                  regs_nxt[in_data_value[12:8]] = in_data_value[7:0];
                end
                code_nxt = {code_r[5:2], in_data_value[15:14]};
                addr_nxt = {addr_r[15:14], in_data_value[13:0]};
              end else if (!pend_r) begin
                code_nxt = {code_r[5:2], in_data_value[15:14]};
                addr_nxt = {addr_r[15:14], in_data_value[13:0]};
                pend_nxt = 1'b1;
              end else begin
                code_w   = {in_data_value[7:4], code_r[1:0]};
                code_nxt = code_w;
                addr_nxt = {in_data_value[1:0], addr_r[13:0]};
                pend_nxt = 1'b0;
                if (code_w[5] && regs_r[1][4]) begin
                  if (regs_r[23][7:6] == DMA_FILL) begin
                    fillp_nxt = 1'b1;
                  end else if (regs_r[23][7:6] == DMA_COPY) begin
                    cnt_nxt   = dma_len;
                    src_nxt   = {regs_r[22], regs_r[21]};
                    state_nxt = S_CP_RD;
                  end
                end
                if (!code_w[0] && !code_w[5]) begin
                  state_nxt = S_PF_A;
                end
              end
            end
            FN_STAT_RD: begin
              pend_nxt = 1'b0;
              rd_nxt   = {6'd0, stat_r};
              stat_nxt = stat_r & ~STAT_ONESHOT;
            end
            FN_DATA_WR: begin
              pend_nxt  = 1'b0;
              state_nxt = S_DW;
            end
            FN_DATA_RD: begin
              pend_nxt  = 1'b0;
              rd_nxt    = pf_r;
              state_nxt = S_PF_A;
            end
            FN_INT_ACK: begin
              if (in_ack_level == IPL_VERT) begin
                stat_nxt = stat_r & ~STAT_VINT;
              end else if (in_ack_level == IPL_HORZ) begin
                lip_nxt = 1'b0;
              end
            end
            FN_LINE: begin
              lip_nxt = 1'b0;
              if (in_line_number == 9'd0) begin
                cnt9 = {1'b0, regs_r[10]};
              end
              if (32'(in_line_number) < ACTIVE_LINE_COUNT) begin
                stat_nxt = stat_r & ~STAT_VBLANK;
                if (cnt9 == 9'd0) begin
                  lic_nxt = {1'b0, regs_r[10]};
                  lip_nxt = 1'b1;
                end else begin
                  lic_nxt = cnt9 - 9'd1;
                end
              end else begin
                if (32'(in_line_number) == ACTIVE_LINE_COUNT) begin
                  stat_nxt = stat_r | STAT_VBLANK | STAT_VINT;
                end
                lic_nxt = {1'b0, regs_r[10]};
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Prefetch: read all sources at the address, then pick one.
      S_PF_A: begin
        state_nxt = S_PF_B;
      end

      S_PF_B: begin
        vram_ra = addr_nbr[VA_W-1:0];
        hi_nxt  = vram_rd;
        case (code_r[3:0])
          RS_VRAM: begin
            state_nxt = S_PF_C;
          end
          RS_CRAM: begin
            pf_nxt    = ci_ok ? {4'd0, cram_rd} : 16'd0;
            addr_nxt  = addr_step;
            state_nxt = S_DONE;
          end
          RS_VSRAM: begin
            pf_nxt    = vi_ok ? {5'd0, vsram_rd} : 16'd0;
            addr_nxt  = addr_step;
            state_nxt = S_DONE;
          end
          default: begin
            pf_nxt    = 16'd0;
            addr_nxt  = addr_step;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_PF_C: begin
        pf_nxt    = {hi_r, vram_rd};
        addr_nxt  = addr_step;
        state_nxt = S_DONE;
      end

      // Data port write to the selected target, or the start of an armed fill DMA.
      S_DW: begin
        if (fillp_r) begin
          cnt_nxt   = dma_len;
          first_nxt = 1'b1;
          state_nxt = S_FILL;
        end else begin
          addr_nxt  = addr_step;
          state_nxt = S_DONE;
          case (code_r[2:0])
            WT_VRAM: begin
              vram_we   = 1'b1;
              vram_wd   = data_r[15:8];
              addr_nxt  = addr_r;
              state_nxt = S_WR_LO;
            end
            WT_CRAM: begin
              cram_we = ci_ok;
            end
            WT_VSRAM: begin
              vsram_we = vi_ok;
            end
            default: begin
            end
          endcase
        end
      end

      S_WR_LO: begin
        vram_we   = 1'b1;
        vram_wa   = addr_nbr[VA_W-1:0];
        vram_wd   = data_r[7:0];
        addr_nxt  = addr_step;
        state_nxt = S_DONE;
      end

      // Fill DMA: low byte first, then the high byte for the rest.
      S_FILL: begin
        vram_we   = 1'b1;
        vram_wd   = first_r ? data_r[7:0] : data_r[15:8];
        addr_nxt  = addr_step;
        cnt_nxt   = cnt_r - 16'd1;
        first_nxt = 1'b0;
        if (cnt_r == 16'd1) begin
          regs_nxt[19] = 8'd0;
          regs_nxt[20] = 8'd0;
          fillp_nxt    = 1'b0;
          state_nxt    = S_DONE;
        end
      end

      // Copy DMA: one read and one write per byte.
      S_CP_RD: begin
        vram_ra   = src_r[VA_W-1:0];
        state_nxt = S_CP_WR;
      end

      S_CP_WR: begin
        vram_we   = 1'b1;
        vram_wd   = vram_rd;
        addr_nxt  = addr_step;
        src_nxt   = src_r + 16'd1;
        cnt_nxt   = cnt_r - 16'd1;
        state_nxt = S_CP_RD;
        if (cnt_r == 16'd1) begin
          regs_nxt[21] = src_nxt[7:0];
          regs_nxt[22] = src_nxt[15:8];
          regs_nxt[19] = 8'd0;
          regs_nxt[20] = 8'd0;
          state_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, registered outputs and the result transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= 16'd0;
      code_r      <= 6'd0;
      pend_r      <= 1'b0;
      pf_r        <= 16'd0;
      fillp_r     <= 1'b0;
      stat_r      <= STAT_RESET;
      lip_r       <= 1'b0;
      lic_r       <= 9'd0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= 8'd0;
      end
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      code_r      <= code_nxt;
      pend_r      <= pend_nxt;
      pf_r        <= pf_nxt;
      fillp_r     <= fillp_nxt;
      stat_r      <= stat_nxt;
      lip_r       <= lip_nxt;
      lic_r       <= lic_nxt;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
      clr_r       <= clr_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    rd_r    <= rd_nxt;
    cnt_r   <= cnt_nxt;
    src_r   <= src_nxt;
    first_r <= first_nxt;
    hi_r    <= hi_nxt;
    if (state_r == S_DONE) begin
      out_rd_r <= rd_r;
      if (stat_r[7] && regs_r[1][5]) begin
        out_ipl_r <= IPL_VERT;
      end else if (lip_r && regs_r[0][4]) begin
        out_ipl_r <= IPL_HORZ;
      end else begin
        out_ipl_r <= IPL_NONE;
      end
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_ipl_level = out_ipl_r;

endmodule

// ===== hw/rtl/vpi_vram.sv =====
module vpi_vram #(
  parameter int BYTES = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:BYTES-1];
  logic [7:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vpi_wram.sv =====
module vpi_wram #(
  parameter int W     = 12,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0]     mem [0:DEPTH-1];
  logic [DEPTH-1:0] valid_r;
  logic [W-1:0]     rdata_r;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
  end

  assign rdata = rdata_r;

endmodule

// ===== sim/vpi_checker.sv =====
`timescale 1ns / 100ps

// Watches the host port of the video processor interface, predicts each
// result from its own copy of the processor state and compares.
module vpi_checker
  import vpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_data_value,
  input  logic [2:0]  in_ack_level,
  input  logic [8:0]  in_line_number,
  input  logic        out_valid,
  input  logic [15:0] out_read_data,
  input  logic [2:0]  out_ipl_level,
  output int          fail_count,
  output int          pending_count
);

  localparam int VRAM_BYTES  = 65536;
  localparam int CRAM_WORDS  = 64;
  localparam int VSRAM_WORDS = 40;
  localparam int REG_COUNT   = 24;
  localparam int VISIBLE_LINES = 224;

  typedef struct packed {
    logic [15:0] read_data;
    logic [2:0]  ipl;
  } port_result_t;

  logic [7:0]  regs [REG_COUNT];
  logic [7:0]  vram [VRAM_BYTES];
  logic [11:0] cram [CRAM_WORDS];
  logic [10:0] vsram [VSRAM_WORDS];
  logic [15:0] addr;
  logic [5:0]  code;
  logic        second_word;
  logic [15:0] prefetch;
  logic        fill_armed;
  logic [9:0]  status;
  logic        hirq_flag;
  logic [8:0]  hirq_count;

  port_result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [31:0] dma_count();
    logic [15:0] n;
    n = {regs[20], regs[19]};
    return (n == 0) ? 32'hFFFF : 32'(n);
  endfunction

  function automatic void advance_addr();
    addr = addr + 16'(regs[15]);
  endfunction

  function automatic void fetch_word();
    logic [15:0] w;
    w = addr >> 1;
    case (code[3:0])
      RS_VRAM:  prefetch = {vram[addr], vram[16'(addr + 16'd1)]};
      RS_CRAM:  prefetch = (w[5:0] < CRAM_WORDS) ? 16'(cram[w[5:0]]) : 16'd0;
      RS_VSRAM: prefetch = (w < VSRAM_WORDS) ? 16'(vsram[w]) : 16'd0;
      default:  prefetch = 16'd0;
    endcase
  endfunction

  function automatic void host_control(input logic [15:0] v);
    logic [31:0] n;
    logic [15:0] src;
    if (v[15:14] == 2'b10 && !second_word) begin
      if (v[12:8] < REG_COUNT) regs[v[12:8]] = v[7:0];
      code = {code[5:2], v[15:14]};
      addr = {addr[15:14], v[13:0]};
      return;
    end
    if (!second_word) begin
      addr = {addr[15:14], v[13:0]};
      code = {code[5:2], v[15:14]};
      second_word = 1'b1;
      return;
    end
    addr = {v[1:0], addr[13:0]};
    code = {v[7:4], code[1:0]};
    second_word = 1'b0;
    if (code[5] && regs[1][4]) begin
      if (regs[23][7:6] == DMA_FILL) begin
        fill_armed = 1'b1;
      end else if (regs[23][7:6] == DMA_COPY) begin
        n = dma_count();
        src = {regs[22], regs[21]};
        for (int i = 0; i < n; i++) begin
          vram[addr] = vram[src];
          src = src + 16'd1;
          advance_addr();
        end
        {regs[22], regs[21]} = src;
        regs[19] = 8'd0;
        regs[20] = 8'd0;
      end
    end
    if (!code[0] && !code[5]) begin
      fetch_word();
      advance_addr();
    end
  endfunction

  function automatic void host_data_write(input logic [15:0] v);
    logic [31:0] n;
    logic [15:0] w;
    w = addr >> 1;
    second_word = 1'b0;
    if (fill_armed) begin
      n = dma_count();
      vram[addr] = v[7:0];
      advance_addr();
      for (int i = 1; i < n; i++) begin
        vram[addr] = v[15:8];
        advance_addr();
      end
      regs[19] = 8'd0;
      regs[20] = 8'd0;
      fill_armed = 1'b0;
      return;
    end
    case (code[2:0])
      WT_VRAM: begin
        vram[addr] = v[15:8];
        vram[16'(addr + 16'd1)] = v[7:0];
      end
      WT_CRAM:  if (w[5:0] < CRAM_WORDS) cram[w[5:0]] = 12'(v & CRAM_MASK);
      WT_VSRAM: if (w < VSRAM_WORDS) vsram[w] = 11'(v & VSRAM_MASK);
      default: ;
    endcase
    advance_addr();
  endfunction

  function automatic void start_line(input logic [8:0] line);
    hirq_flag = 1'b0;
    if (line == 0) hirq_count = 9'(regs[10]);
    if (line < VISIBLE_LINES) begin
      status = status & ~STAT_VBLANK;
      if (hirq_count == 0) begin
        hirq_count = 9'(regs[10]);
        hirq_flag = 1'b1;
      end else begin
        hirq_count = hirq_count - 9'd1;
      end
    end else begin
      if (line == VISIBLE_LINES) status = status | STAT_VBLANK | STAT_VINT;
      hirq_count = 9'(regs[10]);
    end
  endfunction

  // Applies one host transaction and returns the port result it causes.
  function automatic port_result_t apply_host_op(input logic [2:0] fn, input logic [15:0] v,
                                                 input logic [2:0] lvl, input logic [8:0] line);
    port_result_t r;
    r.read_data = 16'd0;
    case (fn)
      FN_CTRL_WR: host_control(v);
      FN_STAT_RD: begin
        second_word = 1'b0;
        r.read_data = 16'(status);
        status = status & ~STAT_ONESHOT;
      end
      FN_DATA_WR: host_data_write(v);
      FN_DATA_RD: begin
        second_word = 1'b0;
        r.read_data = prefetch;
        fetch_word();
        advance_addr();
      end
      FN_INT_ACK: begin
        if (lvl == IPL_VERT) status = status & ~STAT_VINT;
        else if (lvl == IPL_HORZ) hirq_flag = 1'b0;
      end
      FN_LINE: start_line(line);
      default: ;
    endcase
    r.ipl = IPL_NONE;
    if (hirq_flag && regs[0][4]) r.ipl = IPL_HORZ;
    if ((status & STAT_VINT) != 0 && regs[1][5]) r.ipl = IPL_VERT;
    return r;
  endfunction

  initial begin
    foreach (regs[i]) regs[i] = 8'd0;
    foreach (vram[i]) vram[i] = 8'd0;
    foreach (cram[i]) cram[i] = 12'd0;
    foreach (vsram[i]) vsram[i] = 11'd0;
    addr = 16'd0;
    code = 6'd0;
    second_word = 1'b0;
    prefetch = 16'd0;
    fill_armed = 1'b0;
    status = STAT_RESET;
    hirq_flag = 1'b0;
    hirq_count = 9'd0;
    fail_count = 0;
  end

  // Predict on each accepted transaction, then compare each strobed result.
  always @(posedge clk) begin
    port_result_t e;
    if (rst_n) begin
      if (start && !busy)
        expected_results.push_back(apply_host_op(in_func, in_data_value, in_ack_level,
                                                 in_line_number));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_data %h ipl_level %0d", out_read_data,
                 out_ipl_level);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_read_data !== e.read_data) begin
            $error("read_data: expected %h, actual %h", e.read_data, out_read_data);
            fail_count++;
          end
          if (out_ipl_level !== e.ipl) begin
            $error("ipl_level: expected %0d, actual %0d", e.ipl, out_ipl_level);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import vpi_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_func = '0;
  logic [15:0] in_data_value = '0;
  logic [2:0]  in_ack_level = '0;
  logic [8:0]  in_line_number = '0;
  logic        out_valid;
  logic [15:0] out_read_data;
  logic [2:0]  out_ipl_level;
  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  int          sent_count = 0;
  int          line_pos = 0;

  always #6 clk = ~clk;

  video_port_interface_with_dma i_dut (.*);

  vpi_checker i_checker (.*);

  // Any cycle without a handshake counts toward the watchdog.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one transaction and holds it until the block takes it. Start stays
  // high after the accepting edge; the block is busy then, and the next call or
  // the caller drops it.
  task automatic host_op(input logic [2:0] fn, input logic [15:0] v,
                         input logic [2:0] lvl = 3'd0, input logic [8:0] line = 9'd0,
                         input int gap = 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_data_value <= v;
    in_ack_level <= lvl;
    in_line_number <= line;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  task automatic set_reg(input logic [4:0] idx, input logic [7:0] val, input int gap = 0);
    host_op(FN_CTRL_WR, {3'b100, idx, val}, 3'd0, 9'd0, gap);
  endtask

  // Two-word command: code bits 5..0 and a 16-bit address.
  task automatic command(input logic [5:0] cd, input logic [15:0] a, input int gap = 0);
    host_op(FN_CTRL_WR, {cd[1:0], a[13:0]}, 3'd0, 9'd0, gap);
    host_op(FN_CTRL_WR, {8'd0, cd[5:2], 2'b00, a[15:14]}, 3'd0, 9'd0, gap);
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [5:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 6'h01;
      1: return 6'h03;
      2: return 6'h05;
      3: return 6'h00;
      4: return 6'h08;
      5: return 6'h04;
      default: return 6'($urandom);
    endcase
  endfunction

  initial begin
    int gap;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: registers, each target, index limits, both DMA kinds, interrupts.
    set_reg(5'd15, 8'd2);
    set_reg(5'd1, 8'h30);
    set_reg(5'd0, 8'h10);
    set_reg(5'd31, 8'hFF);
    command(6'h01, 16'hFFFF);
    host_op(FN_DATA_WR, 16'hFFFF);
    command(6'h03, 16'h007E);
    host_op(FN_DATA_WR, 16'hFFFF);
    command(6'h05, 16'h0050);
    host_op(FN_DATA_WR, 16'h1234);
    command(6'h00, 16'hFFFF);
    host_op(FN_DATA_RD, 16'h0);
    command(6'h04, 16'h0050);
    host_op(FN_DATA_RD, 16'h0);
    set_reg(5'd19, 8'h10);
    set_reg(5'd20, 8'h00);
    set_reg(5'd23, 8'h80);
    command(6'h21, 16'h0100);
    host_op(FN_DATA_WR, 16'hA55A);
    set_reg(5'd19, 8'h08);
    set_reg(5'd21, 8'h00);
    set_reg(5'd22, 8'h01);
    set_reg(5'd23, 8'hC0);
    command(6'h20, 16'h0400);
    host_op(FN_LINE, 16'h0, 3'd0, 9'd224);
    host_op(FN_STAT_RD, 16'h0);
    host_op(FN_INT_ACK, 16'h0, 3'd6);
    host_op(7, 16'hFFFF, 3'd7, 9'h1FF);
    start <= 1'b0;

    // Pause until every expected result is back.
    while (pending_count != 0) @(posedge clk);

    // Random: mostly well-formed sequences, some single noise transactions.
    set_reg(5'd10, 8'd3);
    while (sent_count < 1350) begin
      gap = pick_gap();
      case ($urandom_range(0, 9))
        0, 1: begin
          command(pick_code(), 16'($urandom), gap);
          repeat ($urandom_range(1, 4))
            host_op($urandom_range(0, 1) ? FN_DATA_WR : FN_DATA_RD, 16'($urandom),
                    3'd0, 9'd0, pick_gap());
        end
        2: set_reg(5'($urandom_range(0, 23)), 8'($urandom), gap);
        3: begin
          set_reg(5'd19, 8'($urandom_range(1, 40)), gap);
          set_reg(5'd20, 8'd0);
          set_reg(5'd21, 8'($urandom));
          set_reg(5'd22, 8'($urandom));
          set_reg(5'd23, {2'($urandom), 6'($urandom)});
          set_reg(5'd1, 8'h30 | 8'($urandom_range(0, 15)));
          command({1'b1, 5'($urandom)}, 16'($urandom));
          host_op(FN_DATA_WR, 16'($urandom), 3'd0, 9'd0, pick_gap());
        end
        4, 5: begin
          host_op(FN_LINE, 16'($urandom), 3'($urandom), 9'(line_pos), gap);
          line_pos = (line_pos == 261) ? 0 : line_pos + 1;
        end
        6: host_op(FN_INT_ACK, 16'($urandom), $urandom_range(0, 1) ? 3'($urandom) :
                   ($urandom_range(0, 1) ? IPL_VERT : IPL_HORZ), 9'($urandom), gap);
        7: host_op(FN_STAT_RD, 16'($urandom), 3'($urandom), 9'($urandom), gap);
        8: set_reg(5'($urandom_range(0, 31)), 8'($urandom), gap);
        default: host_op(3'($urandom), 16'($urandom), 3'($urandom),
                         9'($urandom_range(0, 511)), gap);
      endcase
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d host transactions: register and command writes, data",
             sent_count);
    $display("reads and writes on all targets, fill and copy DMA, scanlines, acks.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
